@@ design/ilst_pkg.sv @@
// Shared definitions for the indexed list engine: operation codes,
// the per-cycle command struct sent to the storage cells, and defaults.
// Depends on nothing; used by ilst_cell and indexed_list_engine.
`default_nettype none

package ilst_pkg;

    localparam int DEFAULT_CAPACITY = 16;
    localparam int MODE_W           = 3;
    localparam int DATA_W           = 32;

    localparam logic [MODE_W-1:0] MODE_APPEND   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PREPEND  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DEL_LAST = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DEL_FRST = 3'd3;
    localparam logic [MODE_W-1:0] MODE_READ     = 3'd4;
    localparam logic [MODE_W-1:0] MODE_WRITE    = 3'd5;
    localparam logic [MODE_W-1:0] MODE_INSERT   = 3'd6;
    localparam logic [MODE_W-1:0] MODE_DEL_AT   = 3'd7;

    // Broadcast to every cell; at most one flag is set in a cycle.
    typedef struct packed {
        logic ins;   // open a gap at pos and load the new value there
        logic del;   // remove pos and close the gap from the right
        logic wr;    // overwrite pos
        logic rd;    // present pos on the read bus
    } t_cmd;

endpackage

`default_nettype wire

@@ design/ilst_cell.sv @@
// One storage cell of the indexed list: holds a single entry and trades
// data with its left and right neighbors when the list shifts.
// Depends on ilst_pkg.
`default_nettype none

module ilst_cell
    import ilst_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  wire logic              i_clk,
    input  wire t_cmd              i_cmd,
    input  wire logic [CNT_W-1:0]  i_pos,
    input  wire logic [CNT_W-1:0]  i_used,
    input  wire logic [DATA_W-1:0] i_value,
    input  wire logic [DATA_W-1:0] i_left,
    input  wire logic [DATA_W-1:0] i_right,
    output logic      [DATA_W-1:0] o_data,
    output logic      [DATA_W-1:0] o_rd
);

    localparam logic [CNT_W-1:0] K   = CNT_W'(IDX);
    localparam logic [CNT_W-1:0] KP1 = CNT_W'(IDX + 1);

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;
    logic              at_pos;

    assign at_pos = (K == i_pos);

    always_comb begin
        n_data = r_data;
        if (i_cmd.ins) begin
            if (at_pos) begin
                n_data = i_value;
            end else if ((K > i_pos) && (K <= i_used)) begin
                n_data = i_left;
            end
        end else if (i_cmd.del) begin
            // The old last entry becomes unused, so it may simply hold.
            if ((K >= i_pos) && (KP1 < i_used)) begin
                n_data = i_right;
            end
        end else if (i_cmd.wr && at_pos) begin
            n_data = i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_rd   = (i_cmd.rd && at_pos) ? r_data : '0;

endmodule

`default_nettype wire

@@ design/indexed_list_engine.sv @@
// Top level of the indexed list engine: operation decode, length count,
// the row of ilst_cell storage cells and the registered result.
// Depends on ilst_pkg and ilst_cell.
`default_nettype none

// The engine keeps an ordered list of up to CAPACITY signed 32-bit values.
// A request is taken on any cycle with start high; busy never rises, so a
// new request may follow in every cycle. Each request produces exactly one
// result in the next cycle, shown on o_ok, o_read_value and o_count for a
// single cycle while o_done is high; the receiver must take it then. All
// cells of the row update together in the request's cycle, each one
// loading the new value or its left or right neighbor's entry, so shifts
// of any length happen at once. Rejected requests leave the list unchanged
// and report a read value of zero. The list is empty after reset.

module indexed_list_engine
    import ilst_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [MODE_W-1:0] i_mode,
    input  wire logic [CNT_W-1:0]  i_index,
    input  wire logic [DATA_W-1:0] i_value,
    output logic                   o_done,
    output logic                   o_ok,
    output logic      [DATA_W-1:0] o_read_value,
    output logic      [CNT_W-1:0]  o_count
);

    localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);

    logic [CNT_W-1:0]  r_used;
    logic [CNT_W-1:0]  n_used;
    logic              r_done;
    logic              r_ok;
    logic [DATA_W-1:0] r_rd;
    logic [DATA_W-1:0] n_rd;

    logic              accept;
    logic              ok;
    logic              has_room;
    logic              not_empty;
    logic              idx_lt;
    logic              idx_le;
    logic [CNT_W-1:0]  pos;
    t_cmd              cmd_raw;
    t_cmd              cmd;

    logic [DATA_W-1:0] cell_data [CAPACITY];
    logic [DATA_W-1:0] cell_rd   [CAPACITY];

    assign busy      = 1'b0;
    assign accept    = start && !busy;
    assign has_room  = (r_used < CAP);
    assign not_empty = (r_used != '0);
    assign idx_lt    = (i_index < r_used);
    assign idx_le    = (i_index <= r_used);

    always_comb begin
        ok      = 1'b0;
        pos     = i_index;
        cmd_raw = '0;
        case (i_mode)
            MODE_APPEND: begin
                ok          = has_room;
                pos         = r_used;
                cmd_raw.ins = 1'b1;
            end
            MODE_PREPEND: begin
                ok          = has_room;
                pos         = '0;
                cmd_raw.ins = 1'b1;
            end
            MODE_DEL_LAST: begin
                ok          = not_empty;
                pos         = r_used - CNT_W'(1);
                cmd_raw.del = 1'b1;
            end
            MODE_DEL_FRST: begin
                ok          = not_empty;
                pos         = '0;
                cmd_raw.del = 1'b1;
            end
            MODE_READ: begin
                ok         = idx_lt;
                cmd_raw.rd = 1'b1;
            end
            MODE_WRITE: begin
                ok         = idx_lt;
                cmd_raw.wr = 1'b1;
            end
            MODE_INSERT: begin
                ok          = has_room && idx_le;
                cmd_raw.ins = 1'b1;
            end
            MODE_DEL_AT: begin
                ok          = idx_lt;
                cmd_raw.del = 1'b1;
            end
            default: begin
                ok      = 1'b0;
                cmd_raw = '0;
            end
        endcase
    end

    assign cmd = (accept && ok) ? cmd_raw : '0;

    always_comb begin
        n_used = r_used;
        if (cmd.ins) begin
            n_used = r_used + CNT_W'(1);
        end else if (cmd.del) begin
            n_used = r_used - CNT_W'(1);
        end
    end

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [DATA_W-1:0] left;
        logic [DATA_W-1:0] right;
        if (k == 0) begin : g_first
            assign left = '0;
        end else begin : g_mid_l
            assign left = cell_data[k-1];
        end
        if (k == CAPACITY - 1) begin : g_last
            assign right = '0;
        end else begin : g_mid_r
            assign right = cell_data[k+1];
        end
        ilst_cell #(
            .IDX   (k),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (cmd),
            .i_pos   (pos),
            .i_used  (r_used),
            .i_value (i_value),
            .i_left  (left),
            .i_right (right),
            .o_data  (cell_data[k]),
            .o_rd    (cell_rd[k])
        );
    end

    // Only the addressed cell drives a nonzero value onto the read bus.
    always_comb begin
        n_rd = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            n_rd = n_rd | cell_rd[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_done <= 1'b0;
            r_ok   <= 1'b0;
        end else begin
            r_used <= n_used;
            r_done <= accept;
            r_ok   <= accept && ok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd <= n_rd;
    end

    assign o_done       = r_done;
    assign o_ok         = r_ok;
    assign o_read_value = r_rd;
    assign o_count      = r_used;

    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_done)
        else $error("result strobe missing after an accepted request");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_count <= CAP)
        else $error("length count exceeds capacity");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_ok) |-> (o_read_value == '0))
        else $error("rejected request returned a nonzero read value");

    a_reject_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_ok) |-> (o_count == $past(o_count)))
        else $error("rejected request changed the length");

endmodule

`default_nettype wire
